@@ rtl/text_console_cursor_grid_top_defines.svh @@
`ifndef TEXT_CONSOLE_CURSOR_GRID_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_GRID_TOP_DEFINES_SVH

// implication checked on the same edge
`define TCCG_ASSERT_IMP(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("tccg: assertion failed");

// implication checked on the following edge
`define TCCG_ASSERT_NXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("tccg: assertion failed");

`endif

@@ rtl/tccg_pkg.sv @@
package tccg_pkg;

    localparam int MAX_COLS   = 128;
    localparam int MAX_ROWS   = 64;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int CELL_AW    = COL_W + ROW_W;
    localparam int CHAR_W     = 8;
    localparam int CCOUNT_W   = 8;
    localparam int RCOUNT_W   = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 1'd1;

    localparam logic [CCOUNT_W-1:0] COLS_RESET = 8'd80;
    localparam logic [RCOUNT_W-1:0] ROWS_RESET = 7'd25;

    localparam logic [CHAR_W-1:0] CH_SPACE    = 8'd32;
    localparam logic [CHAR_W-1:0] CH_NL       = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR       = 8'd13;
    localparam logic [CHAR_W-1:0] CH_TAB      = 8'd9;
    localparam logic [CHAR_W-1:0] CH_BS       = 8'd8;
    localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'd32;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'd127;
    localparam logic [CCOUNT_W-1:0] TAB_STEP  = 8'd4;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_HOME  = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] char_code;
        logic [COL_W-1:0]  read_col;
        logic [ROW_W-1:0]  read_row;
    } in_item_t;

    typedef struct packed {
        logic              draw_valid;
        logic [COL_W-1:0]  draw_col;
        logic [ROW_W-1:0]  draw_row;
        logic [CHAR_W-1:0] draw_char;
        logic              full_redraw;
        logic              present_request;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [CHAR_W-1:0] read_char;
    } out_item_t;

    // one transaction between the front end and the cell stage
    typedef struct packed {
        logic              rd;
        logic              oob;
        logic              blank;
        logic              wr;
        logic              fresh;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              dv;
        logic [COL_W-1:0]  dc;
        logic [ROW_W-1:0]  dr;
        logic [CHAR_W-1:0] dch;
        logic              redraw;
        logic              present;
        logic [COL_W-1:0]  cur_col;
        logic [ROW_W-1:0]  cur_row;
    } stage_t;

endpackage

@@ rtl/text_console_cursor_grid_top.sv @@
// An accepted transaction passes the stage register, then the output queue.
// Throughput: one transaction per cycle while op_stall is low; the written-marks
//   memory is read at accept and written back on the next edge, with a one-entry bypass.
// Output queue of four entries; input stalls while queue and cell stage hold four.
// Reset: 80x25, cursor and ring offset zero, all rows blank; the character and
//   mark memories are not cleared and need no clearing pass.
module text_console_cursor_grid_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            op_valid,
    output logic                            op_stall,
    input  tccg_pkg::in_item_t              op_data,
    output logic                            res_valid,
    input  logic                            res_stall,
    output tccg_pkg::out_item_t             res_data,
    input  logic                            cfg_we,
    input  logic [tccg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tccg_pkg::CFG_DATA_W-1:0] cfg_data
);

    import tccg_pkg::*;

    localparam logic [OUTQ_AW:0] OUTQ_FULL = (OUTQ_AW + 1)'(OUTQ_DEPTH);

    logic                accept;
    logic                chars_we, chars_re, marks_re, marks_we;
    logic [CELL_AW-1:0]  chars_waddr, chars_raddr;
    logic [CHAR_W-1:0]   chars_wdata, char_q;
    logic [ROW_W-1:0]    marks_raddr, marks_waddr;
    logic [MAX_COLS-1:0] marks_wdata, marks_q;
    logic                stage_valid;
    stage_t              stage;
    out_item_t           result;
    logic [OUTQ_AW:0]    q_count;
    logic [OUTQ_AW:0]    occupancy;

    assign occupancy = q_count + (OUTQ_AW + 1)'(stage_valid);
    assign op_stall  = (occupancy >= OUTQ_FULL);
    assign accept    = op_valid & ~op_stall;

    tccg_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .item        (op_data),
        .chars_we    (chars_we),
        .chars_waddr (chars_waddr),
        .chars_wdata (chars_wdata),
        .chars_re    (chars_re),
        .chars_raddr (chars_raddr),
        .marks_re    (marks_re),
        .marks_raddr (marks_raddr),
        .stage_valid (stage_valid),
        .stage       (stage)
    );

    tccg_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_COLS * MAX_ROWS)
    ) u_chars (
        .clk   (clk),
        .we    (chars_we),
        .waddr (chars_waddr),
        .wdata (chars_wdata),
        .re    (chars_re),
        .raddr (chars_raddr),
        .rdata (char_q)
    );

    tccg_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_marks (
        .clk   (clk),
        .we    (marks_we),
        .waddr (marks_waddr),
        .wdata (marks_wdata),
        .re    (marks_re),
        .raddr (marks_raddr),
        .rdata (marks_q)
    );

    tccg_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .stage       (stage),
        .marks_q     (marks_q),
        .char_q      (char_q),
        .marks_we    (marks_we),
        .marks_waddr (marks_waddr),
        .marks_wdata (marks_wdata),
        .result      (result)
    );

    tccg_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (stage_valid),
        .push_data (result),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .count     (q_count)
    );

endmodule

@@ rtl/tccg_ram.sv @@
module tccg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/tccg_front.sv @@
module tccg_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tccg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tccg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           accept,
    input  tccg_pkg::in_item_t             item,
    output logic                           chars_we,
    output logic [tccg_pkg::CELL_AW-1:0]   chars_waddr,
    output logic [tccg_pkg::CHAR_W-1:0]    chars_wdata,
    output logic                           chars_re,
    output logic [tccg_pkg::CELL_AW-1:0]   chars_raddr,
    output logic                           marks_re,
    output logic [tccg_pkg::ROW_W-1:0]     marks_raddr,
    output logic                           stage_valid,
    output tccg_pkg::stage_t               stage
);

    import tccg_pkg::*;

    localparam logic [CCOUNT_W-1:0] COLS_LIMIT = CCOUNT_W'(MAX_COLS);
    localparam logic [RCOUNT_W-1:0] ROWS_LIMIT = RCOUNT_W'(MAX_ROWS);

    function automatic logic [CCOUNT_W-1:0] eff_cols(input logic [CCOUNT_W-1:0] n);
        logic [CCOUNT_W-1:0] r;
        if (n == '0)
            r = CCOUNT_W'(1);
        else if (n > COLS_LIMIT)
            r = COLS_LIMIT;
        else
            r = n;
        return r;
    endfunction

    function automatic logic [RCOUNT_W-1:0] eff_rows(input logic [RCOUNT_W-1:0] n);
        logic [RCOUNT_W-1:0] r;
        if (n == '0)
            r = RCOUNT_W'(1);
        else if (n > ROWS_LIMIT)
            r = ROWS_LIMIT;
        else
            r = n;
        return r;
    endfunction

    logic [CCOUNT_W-1:0] cfg_cols_reg, cfg_cols_next;
    logic [RCOUNT_W-1:0] cfg_rows_reg, cfg_rows_next;
    logic [COL_W-1:0]    cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]    cur_row_reg, cur_row_next;
    logic [ROW_W-1:0]    top_reg, top_next;
    logic [MAX_ROWS-1:0] blank_reg, blank_next;
    logic                stage_valid_reg;
    stage_t              stage_reg, stage_next;

    logic [CCOUNT_W-1:0] cols_eff, new_cols_eff, cols_m1;
    logic [RCOUNT_W-1:0] rows_eff, new_rows_eff, rows_m1;
    logic [COL_W-1:0]    clamp_col;
    logic [ROW_W-1:0]    clamp_row;

    logic [CCOUNT_W-1:0] col_n;
    logic [ROW_W:0]      row_n;
    logic                act, wr, rd, scroll, clear, present;
    logic [COL_W-1:0]    wcol;
    logic [CHAR_W-1:0]   wch;
    logic [ROW_W-1:0]    p_w, p_r, blank_idx;

    assign cols_eff = eff_cols(cfg_cols_reg);
    assign rows_eff = eff_rows(cfg_rows_reg);

    // register write: new size, cursor pulled inside it
    always_comb
    begin
        cfg_cols_next = cfg_cols_reg;
        cfg_rows_next = cfg_rows_reg;
        if (cfg_index == CFG_COLUMN_COUNT)
            cfg_cols_next = cfg_data[CCOUNT_W-1:0];
        if (cfg_index == CFG_ROW_COUNT)
            cfg_rows_next = cfg_data[RCOUNT_W-1:0];
        new_cols_eff = eff_cols(cfg_cols_next);
        new_rows_eff = eff_rows(cfg_rows_next);
        cols_m1 = new_cols_eff - 1'b1;
        rows_m1 = new_rows_eff - 1'b1;
        clamp_col = ({1'b0, cur_col_reg} >= new_cols_eff) ? cols_m1[COL_W-1:0] : cur_col_reg;
        clamp_row = ({1'b0, cur_row_reg} >= new_rows_eff) ? rows_m1[ROW_W-1:0] : cur_row_reg;
    end

    always_comb
    begin
        col_n   = {1'b0, cur_col_reg};
        row_n   = {1'b0, cur_row_reg};
        act     = 1'b0;
        wr      = 1'b0;
        rd      = 1'b0;
        scroll  = 1'b0;
        clear   = 1'b0;
        present = 1'b0;
        wcol    = cur_col_reg;
        wch     = CH_SPACE;
        top_next = top_reg;
        p_w = top_reg + cur_row_reg;
        p_r = top_reg + item.read_row;

        case (item.op)
            OP_PUT:
            begin
                act = 1'b1;
                case (item.char_code)
                    CH_NL:
                    begin
                        col_n   = '0;
                        row_n   = row_n + 1'b1;
                        present = 1'b1;
                    end
                    CH_CR:
                    begin
                        col_n = '0;
                    end
                    CH_TAB:
                    begin
                        col_n = (col_n + TAB_STEP) & ~(TAB_STEP - 8'd1);
                    end
                    CH_BS:
                    begin
                        if (cur_col_reg != '0)
                        begin
                            col_n = col_n - 1'b1;
                            wr    = 1'b1;
                            wcol  = cur_col_reg - 1'b1;
                            wch   = CH_SPACE;
                        end
                    end
                    default:
                    begin
                        if (item.char_code inside {[CH_PRINT_LO:CH_PRINT_HI]})
                        begin
                            wr    = 1'b1;
                            wcol  = cur_col_reg;
                            wch   = item.char_code;
                            col_n = col_n + 1'b1;
                        end
                        else
                        begin
                            act = 1'b0;
                        end
                    end
                endcase
                if (act)
                begin
                    if (col_n >= cols_eff)
                    begin
                        col_n = '0;
                        row_n = row_n + 1'b1;
                    end
                    if (row_n >= rows_eff)
                    begin
                        scroll   = 1'b1;
                        top_next = top_reg + 1'b1;
                        row_n    = rows_eff - 1'b1;
                    end
                end
            end
            OP_CLEAR:
            begin
                clear    = 1'b1;
                present  = 1'b1;
                top_next = '0;
                col_n    = '0;
                row_n    = '0;
            end
            OP_HOME:
            begin
                col_n = '0;
                row_n = '0;
            end
            OP_READ:
            begin
                rd = 1'b1;
            end
            default:
            begin
                act = 1'b0;
            end
        endcase

        cur_col_next = col_n[COL_W-1:0];
        cur_row_next = row_n[ROW_W-1:0];
        blank_idx = top_next + row_n[ROW_W-1:0];

        blank_next = blank_reg;
        if (wr)
            blank_next[p_w] = 1'b0;
        if (scroll)
            blank_next[blank_idx] = 1'b1;
        if (clear)
            blank_next = '1;
    end

    always_comb
    begin
        stage_next = '0;
        stage_next.rd      = rd;
        stage_next.wr      = wr;
        stage_next.oob     = ({1'b0, item.read_col} >= cols_eff) ||
                             ({1'b0, item.read_row} >= rows_eff);
        stage_next.blank   = blank_reg[p_r];
        stage_next.fresh   = blank_reg[p_w];
        stage_next.row     = wr ? p_w : p_r;
        stage_next.col     = wr ? wcol : item.read_col;
        stage_next.dv      = wr;
        stage_next.dc      = wr ? wcol : '0;
        stage_next.dr      = wr ? cur_row_reg : '0;
        stage_next.dch     = wr ? wch : '0;
        stage_next.redraw  = scroll | clear;
        stage_next.present = present;
        stage_next.cur_col = cur_col_next;
        stage_next.cur_row = cur_row_next;
    end

    assign chars_we    = accept & wr;
    assign chars_waddr = {p_w, wcol};
    assign chars_wdata = wch;
    assign chars_re    = accept & rd;
    assign chars_raddr = {p_r, item.read_col};
    assign marks_re    = accept & (wr | rd);
    assign marks_raddr = wr ? p_w : p_r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_cols_reg    <= COLS_RESET;
            cfg_rows_reg    <= ROWS_RESET;
            cur_col_reg     <= '0;
            cur_row_reg     <= '0;
            top_reg         <= '0;
            blank_reg       <= '1;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= accept;
            if (cfg_we)
            begin
                cfg_cols_reg <= cfg_cols_next;
                cfg_rows_reg <= cfg_rows_next;
                cur_col_reg  <= clamp_col;
                cur_row_reg  <= clamp_row;
            end
            else if (accept)
            begin
                cur_col_reg <= cur_col_next;
                cur_row_reg <= cur_row_next;
                top_reg     <= top_next;
                blank_reg   <= blank_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_valid = stage_valid_reg;
    assign stage       = stage_reg;

endmodule

@@ rtl/tccg_cell.sv @@
module tccg_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          stage_valid,
    input  tccg_pkg::stage_t              stage,
    input  logic [tccg_pkg::MAX_COLS-1:0] marks_q,
    input  logic [tccg_pkg::CHAR_W-1:0]   char_q,
    output logic                          marks_we,
    output logic [tccg_pkg::ROW_W-1:0]    marks_waddr,
    output logic [tccg_pkg::MAX_COLS-1:0] marks_wdata,
    output tccg_pkg::out_item_t           result
);

    import tccg_pkg::*;

    logic                wb_valid_reg;
    logic [ROW_W-1:0]    wb_row_reg;
    logic [MAX_COLS-1:0] wb_data_reg;
    logic [MAX_COLS-1:0] row_data;
    logic [MAX_COLS-1:0] col_bit;
    logic                hit;

    // write-back of the previous edge is not yet visible in the read data
    assign row_data = (wb_valid_reg && (wb_row_reg == stage.row)) ? wb_data_reg : marks_q;
    assign col_bit  = MAX_COLS'(1) << stage.col;
    assign hit      = row_data[stage.col];

    assign marks_we    = stage_valid & stage.wr;
    assign marks_waddr = stage.row;
    assign marks_wdata = (stage.fresh ? '0 : row_data) | col_bit;

    always_comb
    begin
        result.draw_valid      = stage.dv;
        result.draw_col        = stage.dc;
        result.draw_row        = stage.dr;
        result.draw_char       = stage.dch;
        result.full_redraw     = stage.redraw;
        result.present_request = stage.present;
        result.cursor_col      = stage.cur_col;
        result.cursor_row      = stage.cur_row;
        if (!stage.rd)
            result.read_char = '0;
        else if (stage.oob || stage.blank || !hit)
            result.read_char = CH_SPACE;
        else
            result.read_char = char_q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_valid_reg <= 1'b0;
        end
        else
        begin
            wb_valid_reg <= marks_we;
        end
    end

    always_ff @(posedge clk)
    begin
        if (marks_we)
        begin
            wb_row_reg  <= marks_waddr;
            wb_data_reg <= marks_wdata;
        end
    end

endmodule

@@ rtl/tccg_outq.sv @@
module tccg_outq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  tccg_pkg::out_item_t          push_data,
    output logic                         res_valid,
    input  logic                         res_stall,
    output tccg_pkg::out_item_t          res_data,
    output logic [tccg_pkg::OUTQ_AW:0]   count
);

    import tccg_pkg::*;

    out_item_t          entry_reg [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUTQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUTQ_AW:0]   count_reg, count_next;
    logic               pop;

    assign pop       = res_valid & ~res_stall;
    assign res_valid = (count_reg != '0);
    assign res_data  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (OUTQ_AW + 1)'(push) - (OUTQ_AW + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/tccg_chk.sv @@
`include "text_console_cursor_grid_top_defines.svh"

module tccg_chk (
    input logic                clk,
    input logic                rst_n,
    input logic                op_valid,
    input logic                op_stall,
    input tccg_pkg::in_item_t  op_data,
    input logic                res_valid,
    input logic                res_stall,
    input tccg_pkg::out_item_t res_data
);

    import tccg_pkg::*;

    localparam logic [2:0] MAX_PENDING = 3'(OUTQ_DEPTH + 1);

    logic [2:0] pending_reg, pending_next;
    logic       op_xfer, res_xfer;

    assign op_xfer  = op_valid & ~op_stall;
    assign res_xfer = res_valid & ~res_stall;

    // transactions accepted but not yet delivered
    always_comb
    begin
        pending_next = pending_reg + 3'(op_xfer) - 3'(res_xfer);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `TCCG_ASSERT_IMP(a_pending_bound, 1'b1, pending_reg <= MAX_PENDING)
    `TCCG_ASSERT_IMP(a_no_spurious_result, res_valid, pending_reg != 3'd0)
    `TCCG_ASSERT_IMP(a_idle_accepts, pending_reg == 3'd0, !op_stall)
    `TCCG_ASSERT_NXT(a_result_holds, res_valid && res_stall, res_valid && $stable(res_data))

endmodule

bind text_console_cursor_grid_top tccg_chk u_chk (.*);

@@ test/text_console_cursor_grid_checker.sv @@
module text_console_cursor_grid_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            op_valid,
    input  logic                            op_stall,
    input  tccg_pkg::in_item_t              op_data,
    input  logic                            res_valid,
    input  logic                            res_stall,
    input  tccg_pkg::out_item_t             res_data,
    input  logic                            cfg_we,
    input  logic [tccg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tccg_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              outstanding,
    output int                              mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import tccg_pkg::*;

    logic [CHAR_W-1:0]   grid_chars [MAX_ROWS][MAX_COLS];
    logic [MAX_COLS-1:0] grid_written [MAX_ROWS];
    logic [MAX_ROWS-1:0] row_blank;
    logic [ROW_W-1:0]    top_row;
    int                  cur_col;
    int                  cur_row;
    logic [CCOUNT_W-1:0] col_setting;
    logic [RCOUNT_W-1:0] row_setting;
    out_item_t           expected_responses [$];
    int                  error_count = 0;

    assign mismatches = error_count;

    function automatic int cols_in_use();
        if (col_setting == 0)
        begin
            return 1;
        end
        if (col_setting > MAX_COLS)
        begin
            return MAX_COLS;
        end
        return int'(col_setting);
    endfunction

    function automatic int rows_in_use();
        if (row_setting == 0)
        begin
            return 1;
        end
        if (row_setting > MAX_ROWS)
        begin
            return MAX_ROWS;
        end
        return int'(row_setting);
    endfunction

    function automatic int row_phys(int row);
        return (int'(top_row) + row) % MAX_ROWS;
    endfunction

    function automatic void clamp_cursor();
        if (cur_col >= cols_in_use())
        begin
            cur_col = cols_in_use() - 1;
        end
        if (cur_row >= rows_in_use())
        begin
            cur_row = rows_in_use() - 1;
        end
    endfunction

    // a blank row drops its stale write marks on first use
    function automatic void store_char(int col, int row, logic [CHAR_W-1:0] ch);
        int p;
        p = row_phys(row);
        if (row_blank[p])
        begin
            grid_written[p] = '0;
            row_blank[p] = 1'b0;
        end
        grid_written[p][col] = 1'b1;
        grid_chars[p][col] = ch;
    endfunction

    function automatic logic [CHAR_W-1:0] char_at(int col, int row);
        int p;
        if (col >= cols_in_use() || row >= rows_in_use())
        begin
            return CH_SPACE;
        end
        p = row_phys(row);
        if (row_blank[p] || !grid_written[p][col])
        begin
            return CH_SPACE;
        end
        return grid_chars[p][col];
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] val);
        if (idx == CFG_COLUMN_COUNT)
        begin
            col_setting = val;
        end
        else if (idx == CFG_ROW_COUNT)
        begin
            row_setting = val[RCOUNT_W-1:0];
        end
        clamp_cursor();
    endfunction

    function automatic out_item_t console_response(in_item_t t);
        out_item_t r;
        int        cols;
        int        rows;
        logic      acts;
        r = '0;
        cols = cols_in_use();
        rows = rows_in_use();
        clamp_cursor();
        case (t.op)
            OP_PUT:
            begin
                acts = 1'b1;
                if (t.char_code == CH_NL)
                begin
                    cur_col = 0;
                    cur_row++;
                    r.present_request = 1'b1;
                end
                else if (t.char_code == CH_CR)
                begin
                    cur_col = 0;
                end
                else if (t.char_code == CH_TAB)
                begin
                    cur_col = (cur_col + int'(TAB_STEP)) & ~(int'(TAB_STEP) - 1);
                end
                else if (t.char_code == CH_BS)
                begin
                    if (cur_col > 0)
                    begin
                        cur_col--;
                        store_char(cur_col, cur_row, CH_SPACE);
                        r.draw_valid = 1'b1;
                        r.draw_col = COL_W'(cur_col);
                        r.draw_row = ROW_W'(cur_row);
                        r.draw_char = CH_SPACE;
                    end
                end
                else if (t.char_code < CH_PRINT_LO || t.char_code > CH_PRINT_HI)
                begin
                    acts = 1'b0;
                end
                else
                begin
                    store_char(cur_col, cur_row, t.char_code);
                    r.draw_valid = 1'b1;
                    r.draw_col = COL_W'(cur_col);
                    r.draw_row = ROW_W'(cur_row);
                    r.draw_char = t.char_code;
                    cur_col++;
                end
                if (acts)
                begin
                    if (cur_col >= cols)
                    begin
                        cur_col = 0;
                        cur_row++;
                    end
                    if (cur_row >= rows)
                    begin
                        top_row = ROW_W'((int'(top_row) + 1) % MAX_ROWS);
                        cur_row = rows - 1;
                        row_blank[row_phys(cur_row)] = 1'b1;
                        r.full_redraw = 1'b1;
                    end
                end
            end
            OP_CLEAR:
            begin
                row_blank = '1;
                top_row = '0;
                cur_col = 0;
                cur_row = 0;
                r.full_redraw = 1'b1;
                r.present_request = 1'b1;
            end
            OP_HOME:
            begin
                cur_col = 0;
                cur_row = 0;
            end
            default:
            begin
                r.read_char = char_at(int'(t.read_col), int'(t.read_row));
            end
        endcase
        r.cursor_col = COL_W'(cur_col);
        r.cursor_row = ROW_W'(cur_row);
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    function automatic void check_response(out_item_t want, out_item_t got);
        check_field("draw_valid", want.draw_valid, got.draw_valid);
        check_field("draw_col", want.draw_col, got.draw_col);
        check_field("draw_row", want.draw_row, got.draw_row);
        check_field("draw_char", want.draw_char, got.draw_char);
        check_field("full_redraw", want.full_redraw, got.full_redraw);
        check_field("present_request", want.present_request, got.present_request);
        check_field("cursor_col", want.cursor_col, got.cursor_col);
        check_field("cursor_row", want.cursor_row, got.cursor_row);
        check_field("read_char", want.read_char, got.read_char);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_blank = '1;
            top_row = '0;
            cur_col = 0;
            cur_row = 0;
            col_setting = COLS_RESET;
            row_setting = ROWS_RESET;
            expected_responses.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                apply_register(cfg_index, cfg_data);
            end
            if (op_valid && !op_stall)
            begin
                expected_responses.push_back(console_response(op_data));
            end
            if (res_valid && !res_stall)
            begin
                if (expected_responses.size() == 0)
                begin
                    $error("result transaction with no prediction pending");
                    error_count++;
                end
                else
                begin
                    check_response(expected_responses.pop_front(), res_data);
                end
            end
            outstanding <= expected_responses.size();
        end
    end

endmodule

@@ test/text_console_cursor_grid_top_tb.sv @@
module text_console_cursor_grid_top_tb import tccg_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_MARGIN   = 6;
    localparam int TARGET_ITEMS   = 1400;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  op_valid;
    logic                  op_stall;
    in_item_t              op_data;
    logic                  res_valid;
    logic                  res_stall;
    out_item_t             res_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    outstanding;
    int                    mismatches;

    int burst_left = 0;
    int cols_used = 80;
    int rows_used = 25;
    int items_sent = 0;
    int idle_cycles = 0;
    int stall_mode = 0;
    int mode_left = 0;
    int cycle_count = 0;

    always #6 clk = ~clk;

    text_console_cursor_grid_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_stall  (op_stall),
        .op_data   (op_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    text_console_cursor_grid_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .op_valid    (op_valid),
        .op_stall    (op_stall),
        .op_data     (op_data),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_data    (res_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    // receiver: stall behavior switches between four random modes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else
        begin
            cycle_count = cycle_count + 1;
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 400);
            end
            else
            begin
                mode_left = mode_left - 1;
            end
            case (stall_mode)
                0: res_stall <= 1'b0;
                1: res_stall <= ($urandom_range(0, 3) == 0);
                2: res_stall <= ($urandom_range(0, 9) < 7);
                default: res_stall <= ((cycle_count % 8) < 3);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((op_valid && !op_stall) || (res_valid && !res_stall))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // sender: bursts of random length separated by random gaps
    task automatic issue(in_item_t t);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                op_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        op_valid <= 1'b1;
        op_data <= t;
        do @(posedge clk); while (op_stall);
    endtask

    function automatic in_item_t noise_item();
        in_item_t t;
        t.op = OP_PUT;
        t.char_code = CHAR_W'($urandom);
        t.read_col = COL_W'($urandom);
        t.read_row = ROW_W'($urandom);
        return t;
    endfunction

    task automatic put_char(logic [CHAR_W-1:0] ch);
        in_item_t t;
        t = noise_item();
        t.char_code = ch;
        issue(t);
    endtask

    task automatic read_at(int col, int row);
        in_item_t t;
        t = noise_item();
        t.op = OP_READ;
        t.read_col = COL_W'(col);
        t.read_row = ROW_W'(row);
        issue(t);
    endtask

    task automatic command(op_t op);
        in_item_t t;
        t = noise_item();
        t.op = op;
        issue(t);
    endtask

    task automatic settle();
        op_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_MARGIN) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_COLUMN_COUNT)
        begin
            cols_used = (val == 0) ? 1 : (val > MAX_COLS) ? MAX_COLS : int'(val);
        end
        else
        begin
            rows_used = (val[RCOUNT_W-1:0] == 0) ? 1 :
                        (val[RCOUNT_W-1:0] > MAX_ROWS) ? MAX_ROWS : int'(val[RCOUNT_W-1:0]);
        end
    endtask

    task automatic set_geometry(int cols_val, int rows_val);
        settle();
        write_reg(CFG_COLUMN_COUNT, CFG_DATA_W'(cols_val));
        write_reg(CFG_ROW_COUNT, CFG_DATA_W'(rows_val));
    endtask

    task automatic random_transaction();
        in_item_t t;
        int       pick;
        logic     counted;
        t = noise_item();
        counted = 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            t.char_code = CHAR_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
        end
        else if (pick < 65)
        begin
            t.char_code = CH_NL;
        end
        else if (pick < 69)
        begin
            t.char_code = CH_TAB;
        end
        else if (pick < 73)
        begin
            t.char_code = CH_CR;
        end
        else if (pick < 77)
        begin
            t.char_code = CH_BS;
        end
        else if (pick < 81)
        begin
            counted = 1'b0;
            if ($urandom_range(0, 1) == 0)
            begin
                t.char_code = CHAR_W'($urandom_range(128, 255));
            end
            else
            begin
                do t.char_code = CHAR_W'($urandom_range(0, 31));
                while (t.char_code == CH_NL || t.char_code == CH_CR ||
                       t.char_code == CH_TAB || t.char_code == CH_BS);
            end
        end
        else if (pick < 96)
        begin
            t.op = OP_READ;
            if ($urandom_range(0, 4) != 0)
            begin
                t.read_col = COL_W'($urandom_range(0, cols_used - 1));
                t.read_row = ROW_W'($urandom_range(0, rows_used - 1));
            end
        end
        else if (pick < 99 || $urandom_range(0, 3) != 0)
        begin
            t.op = OP_HOME;
        end
        else
        begin
            t.op = OP_CLEAR;
        end
        issue(t);
        if (counted)
        begin
            items_sent++;
        end
    endtask

    initial
    begin
        int sel;
        int phase_len;
        rst_n = 1'b0;
        op_valid = 1'b0;
        op_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        read_at(0, 0);
        put_char(8'd65);
        put_char(CH_PRINT_LO);
        put_char(CH_PRINT_HI);
        put_char(8'd0);
        put_char(8'd31);
        put_char(8'd128);
        put_char(8'd255);
        put_char(CH_TAB);
        put_char(CH_BS);
        put_char(CH_CR);
        put_char(CH_BS);
        put_char(CH_NL);
        read_at(0, 0);
        read_at(2, 0);
        read_at(3, 0);
        read_at(127, 63);
        read_at(79, 24);
        command(OP_HOME);
        command(OP_CLEAR);
        read_at(0, 0);

        set_geometry(1, 1);
        put_char(8'd120);
        put_char(CH_NL);
        read_at(0, 0);
        set_geometry(0, 0);
        put_char(8'd122);
        set_geometry(255, 127);
        put_char(8'd90);
        set_geometry(128, 64);
        put_char(CH_TAB);

        while (items_sent < TARGET_ITEMS)
        begin
            sel = $urandom_range(0, 9);
            case (sel)
                0: set_geometry(1, 1);
                1: set_geometry(0, 0);
                2: set_geometry(255, 127);
                3: set_geometry(128, 64);
                8: set_geometry($urandom_range(0, 255), $urandom_range(0, 255));
                9:
                begin
                    settle();
                    if ($urandom_range(0, 1) == 0)
                    begin
                        write_reg(CFG_COLUMN_COUNT, CFG_DATA_W'($urandom_range(1, 128)));
                    end
                    else
                    begin
                        write_reg(CFG_ROW_COUNT, CFG_DATA_W'($urandom_range(1, 64)));
                    end
                end
                default: set_geometry($urandom_range(1, 16), $urandom_range(1, 6));
            endcase
            phase_len = $urandom_range(30, 120);
            repeat (phase_len) random_transaction();
        end

        op_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
